FILE: rtl/lps_pkg.sv
// shared types, constants and saturating helpers for the load predictor score block
package lps_pkg;

	typedef logic signed [63:0] sword_t;
	typedef logic signed [47:0] wword_t;

	localparam int unsigned LR_W    = 17;
	localparam int unsigned BW_W    = 30;
	localparam int unsigned SAMP_W  = 17;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned SCORE_W = 63;

	localparam sword_t BW_FULL = 64'sd1000000000;
	localparam sword_t S64_MAX = {1'b0, {63{1'b1}}};
	localparam sword_t S64_MIN = {1'b1, {63{1'b0}}};
	localparam wword_t W_MAX   = {1'b0, {47{1'b1}}};
	localparam wword_t W_MIN   = {1'b1, {47{1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RPT_EC,
		ST_RPT_ER,
		ST_RPT_EB,
		ST_RPT_G,
		ST_RPT_WC,
		ST_RPT_WR,
		ST_RPT_WB,
		ST_RPT_STORE,
		ST_Q_DIV,
		ST_Q_PC,
		ST_Q_PR,
		ST_Q_PB,
		ST_Q_CPU,
		ST_Q_SBW,
		ST_Q_SRAM,
		ST_Q_SCPU,
		ST_OUT
	} lps_state_t;

	typedef struct packed {
		lps_state_t op;
		logic       capture;
		logic       apply;
		logic       mul_start;
		logic       div_start;
	} lps_cmd_t;

	typedef struct packed {
		logic cmd;
		logic init_report;
		logic allocated;
		logic mul_done;
		logic div_done;
		logic out_free;
	} lps_status_t;

	function automatic sword_t sat_add(input sword_t a, input sword_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic sword_t sat_sub(input sword_t a, input sword_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic wword_t sat_w(input sword_t v);
		if (v[63:47] != {17{v[63]}})
			return v[63] ? W_MIN : W_MAX;
		return v[47:0];
	endfunction

endpackage

FILE: rtl/lps_mulq.sv
// bit-serial fixed point multiplier: floor(a*b / 2^frac), saturated to 64 bits
module lps_mulq import lps_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sword_t op_a,
	input  sword_t op_b,
	output logic   done,
	output sword_t result
);

	localparam int unsigned CNT_W = 6;

	logic [127:0]     prod_q;
	logic [63:0]      mag_a_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [63:0] mag_a, mag_b;
	logic [64:0] upper;
	logic        ovf, rem_nz;
	logic [63:0] quo;
	logic [64:0] quo_rnd;

	assign mag_a = op_a[63] ? (64'd0 - op_a) : op_a;
	assign mag_b = op_b[63] ? (64'd0 - op_b) : op_b;
	assign upper = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, mag_a_q} : 65'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q  <= {64'd0, mag_b};
			mag_a_q <= mag_a;
			neg_q   <= op_a[63] ^ op_b[63];
		end else if (busy_q) begin
			prod_q <= {upper, prod_q[63:1]};
		end
	end

	assign ovf     = |prod_q[127:64+FRAC_BITS];
	assign quo     = prod_q[64+FRAC_BITS-1:FRAC_BITS];
	assign rem_nz  = |prod_q[FRAC_BITS-1:0];
	assign quo_rnd = {1'b0, quo} + {64'd0, rem_nz};

	always_comb begin
		if (!neg_q) begin
			result = (ovf || quo[63]) ? S64_MAX : quo;
		end else begin
			result = (ovf || quo_rnd[64] || quo_rnd[63]) ? S64_MIN : (64'd0 - quo_rnd[63:0]);
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/lps_div.sv
// restoring divider for job load, one quotient bit per cycle
module lps_div import lps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SAMP_W-1:0] dividend,
	input  logic [LEN_W-1:0]  divisor,
	output logic              done,
	output logic [SAMP_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(SAMP_W);

	logic [SAMP_W-1:0] rem_q, quo_q;
	logic [LEN_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [SAMP_W-1:0] trial;
	logic              fits;

	assign trial = {rem_q[SAMP_W-2:0], quo_q[SAMP_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SAMP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			// zero length counts as one
			dvs_q <= (divisor == '0) ? LEN_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[SAMP_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/lps_datapath.sv
// datapath: weights, samples, operand selection, shared multiplier, divider
module lps_datapath import lps_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lps_cmd_t           ctl,
	output lps_status_t        sts,
	input  logic               cfg_wr_en,
	input  logic [LR_W-1:0]    cfg_wr_data,
	input  logic               cmd,
	input  logic               init_report,
	input  logic [BW_W-1:0]    bw_sample,
	input  logic [SAMP_W-1:0]  ram_sample,
	input  logic [SAMP_W-1:0]  cpu_sample,
	input  logic               allocated,
	input  logic [SAMP_W-1:0]  job_size,
	input  logic [LEN_W-1:0]   job_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SCORE_W-1:0] score
);

	localparam logic [LR_W-1:0] LR_RESET = LR_W'(((1 << FRAC_BITS) + 5) / 10);
	localparam sword_t ONE = 64'sd1 <<< FRAC_BITS;

	logic [LR_W-1:0]    lr_q;
	wword_t             wc_q, wr_q, wb_q, wbias_q;
	logic [BW_W-1:0]    last_bw_q, bw_q;
	logic [SAMP_W-1:0]  last_ram_q, last_cpu_q, ram_q, cpu_q, size_q;
	logic [LEN_W-1:0]   len_q;
	logic               cmd_q, init_q, alloc_q;
	sword_t             acc_q, g_q, bw2_q, ram2_q, cpu2_q, best_q;
	logic [SAMP_W-1:0]  quo_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;

	sword_t            mul_a, mul_b, mul_r, z, x, y, wc_e, wr_e, wb_e, wbias_e, q_e;
	logic              mul_done, div_done;
	logic [SAMP_W-1:0] div_quo;

	assign x       = {47'd0, last_cpu_q};
	assign y       = {47'd0, last_ram_q};
	assign z       = ({34'd0, bw_q} - {34'd0, last_bw_q}) <<< FRAC_BITS;
	assign wc_e    = {{16{wc_q[47]}}, wc_q};
	assign wr_e    = {{16{wr_q[47]}}, wr_q};
	assign wb_e    = {{16{wb_q[47]}}, wb_q};
	assign wbias_e = {{16{wbias_q[47]}}, wbias_q};
	assign q_e     = {47'd0, quo_q};

	always_comb begin
		mul_a = wc_e;
		mul_b = x;
		case (ctl.op)
			ST_RPT_EC: begin mul_a = wc_e;              mul_b = x;     end
			ST_RPT_ER: begin mul_a = wr_e;              mul_b = y;     end
			ST_RPT_EB: begin mul_a = wb_e;              mul_b = z;     end
			ST_RPT_G:  begin mul_a = {47'd0, lr_q};     mul_b = acc_q; end
			ST_RPT_WC: begin mul_a = g_q;               mul_b = x;     end
			ST_RPT_WR: begin mul_a = g_q;               mul_b = y;     end
			ST_RPT_WB: begin mul_a = g_q;               mul_b = z;     end
			ST_Q_PC:   begin mul_a = wc_e;              mul_b = x;     end
			ST_Q_PR:   begin mul_a = wr_e;              mul_b = y;     end
			ST_Q_PB:   begin mul_a = wb_e;              mul_b = q_e;   end
			ST_Q_SBW:  begin mul_a = bw2_q;             mul_b = bw2_q; end
			ST_Q_SRAM: begin mul_a = ram2_q;            mul_b = ram2_q; end
			ST_Q_SCPU: begin mul_a = cpu2_q;            mul_b = cpu2_q; end
			default:   begin mul_a = wc_e;              mul_b = x;     end
		endcase
	end

	lps_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.result (mul_r)
	);

	lps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (size_q),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q       <= LR_RESET;
			wc_q       <= ONE[47:0];
			wr_q       <= ONE[47:0];
			wb_q       <= ONE[47:0];
			wbias_q    <= ONE[47:0];
			last_bw_q  <= '0;
			last_ram_q <= '0;
			last_cpu_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				lr_q <= cfg_wr_data;
			// a new score may load in the cycle the old one leaves
			if (ctl.apply && (ctl.op == ST_OUT))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (ctl.apply) begin
				case (ctl.op)
					ST_RPT_G:  wbias_q <= sat_w(sat_add(wbias_e, mul_r));
					ST_RPT_WC: wc_q    <= sat_w(sat_add(wc_e, mul_r));
					ST_RPT_WR: wr_q    <= sat_w(sat_add(wr_e, mul_r));
					ST_RPT_WB: wb_q    <= sat_w(sat_add(wb_e, mul_r));
					ST_RPT_STORE: begin
						last_bw_q  <= bw_q;
						last_ram_q <= ram_q;
						last_cpu_q <= cpu_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			init_q  <= init_report;
			bw_q    <= bw_sample;
			ram_q   <= ram_sample;
			cpu_q   <= cpu_sample;
			alloc_q <= allocated;
			size_q  <= job_size;
			len_q   <= job_length;
		end
		if (ctl.apply) begin
			case (ctl.op)
				ST_DECODE: begin
					acc_q  <= {47'd0, cpu_q};
					bw2_q  <= (BW_FULL - {34'd0, last_bw_q}) <<< FRAC_BITS;
					ram2_q <= ONE - y;
					cpu2_q <= ONE - x;
				end
				ST_RPT_EC, ST_RPT_ER: acc_q <= sat_sub(acc_q, mul_r);
				ST_RPT_EB: acc_q <= sat_sub(sat_sub(acc_q, mul_r), wbias_e);
				ST_RPT_G:  g_q   <= mul_r;
				ST_Q_DIV: begin
					quo_q  <= div_quo;
					bw2_q  <= bw2_q - {47'd0, div_quo};
					ram2_q <= ram2_q - {47'd0, size_q};
				end
				ST_Q_PC:  acc_q  <= mul_r;
				ST_Q_PR:  acc_q  <= sat_add(acc_q, mul_r);
				ST_Q_PB:  acc_q  <= sat_add(sat_add(acc_q, mul_r), wbias_e);
				ST_Q_CPU: cpu2_q <= sat_sub(cpu2_q, acc_q);
				ST_Q_SBW: best_q <= mul_r;
				ST_Q_SRAM, ST_Q_SCPU: begin
					if (mul_r > best_q)
						best_q <= mul_r;
				end
				ST_OUT: score_q <= best_q[63] ? '0 : best_q[SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	assign sts.cmd         = cmd_q;
	assign sts.init_report = init_q;
	assign sts.allocated   = alloc_q;
	assign sts.mul_done    = mul_done;
	assign sts.div_done    = div_done;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign score     = score_q;

endmodule

FILE: rtl/lps_ctrl.sv
// controller: sequences the report and query steps over the shared units
module lps_ctrl import lps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  lps_status_t sts,
	output lps_cmd_t    ctl
);

	lps_state_t state_q, state_d;
	logic       issued_q, issued_d;
	logic       is_mul, unit_done, step_done;

	always_comb begin
		case (state_q)
			ST_RPT_EC, ST_RPT_ER, ST_RPT_EB, ST_RPT_G, ST_RPT_WC, ST_RPT_WR, ST_RPT_WB,
			ST_Q_PC, ST_Q_PR, ST_Q_PB, ST_Q_SBW, ST_Q_SRAM, ST_Q_SCPU: is_mul = 1'b1;
			default: is_mul = 1'b0;
		endcase
	end

	assign unit_done = is_mul ? sts.mul_done : sts.div_done;

	always_comb begin
		case (state_q)
			ST_IDLE:                 step_done = 1'b0;
			ST_DECODE, ST_RPT_STORE, ST_Q_CPU: step_done = 1'b1;
			ST_OUT:                  step_done = sts.out_free;
			default:                 step_done = issued_q && unit_done;
		endcase
	end

	// next state
	always_comb begin
		state_d  = state_q;
		issued_d = issued_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.cmd)
					state_d = sts.allocated ? ST_Q_DIV : ST_Q_SBW;
				else
					state_d = sts.init_report ? ST_RPT_STORE : ST_RPT_EC;
			end
			ST_RPT_STORE, ST_OUT: begin
				if (step_done)
					state_d = ST_IDLE;
			end
			ST_Q_CPU: state_d = ST_Q_SBW;
			default: begin
				if (!issued_q) begin
					issued_d = 1'b1;
				end else if (unit_done) begin
					issued_d = 1'b0;
					case (state_q)
						ST_RPT_EC: state_d = ST_RPT_ER;
						ST_RPT_ER: state_d = ST_RPT_EB;
						ST_RPT_EB: state_d = ST_RPT_G;
						ST_RPT_G:  state_d = ST_RPT_WC;
						ST_RPT_WC: state_d = ST_RPT_WR;
						ST_RPT_WR: state_d = ST_RPT_WB;
						ST_RPT_WB: state_d = ST_RPT_STORE;
						ST_Q_DIV:  state_d = ST_Q_PC;
						ST_Q_PC:   state_d = ST_Q_PR;
						ST_Q_PR:   state_d = ST_Q_PB;
						ST_Q_PB:   state_d = ST_Q_CPU;
						ST_Q_SBW:  state_d = ST_Q_SRAM;
						ST_Q_SRAM: state_d = ST_Q_SCPU;
						ST_Q_SCPU: state_d = ST_OUT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl.op        = state_q;
		ctl.capture   = (state_q == ST_IDLE) && in_valid;
		ctl.apply     = step_done;
		ctl.mul_start = is_mul && !issued_q;
		ctl.div_start = (state_q == ST_Q_DIV) && !issued_q;
		in_stall      = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
		end
	end

endmodule

FILE: rtl/lms_load_predictor_score.sv
// load report: 7 serial multiplies plus decode and store; an initial report only decodes and stores
// score query: up to 6 multiplies, plus a divide when the job is allocated
// a single shift-add multiplier is shared by all products
// one transaction at a time; the next is taken while a score still waits at the output
// reset: weights to 1.0, stored samples to zero, learning rate to 0.1, output empty
module lms_load_predictor_score import lps_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LR_W-1:0]    cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic               init_report,
	input  logic [BW_W-1:0]    bw_sample,
	input  logic [SAMP_W-1:0]  ram_sample,
	input  logic [SAMP_W-1:0]  cpu_sample,
	input  logic               allocated,
	input  logic [SAMP_W-1:0]  job_size,
	input  logic [LEN_W-1:0]   job_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SCORE_W-1:0] score
);

	lps_cmd_t    ctl;
	lps_status_t sts;

	lps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	lps_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.init_report (init_report),
		.bw_sample   (bw_sample),
		.ram_sample  (ram_sample),
		.cpu_sample  (cpu_sample),
		.allocated   (allocated),
		.job_size    (job_size),
		.job_length  (job_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.score       (score)
	);

endmodule

FILE: rtl/lps_checker.sv
// port-level checks for the load predictor score block, with bind
module lps_checker import lps_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [SCORE_W-1:0] score
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(score))
		else $error("stalled score changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a transaction");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("score appeared without a transaction in progress");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("score appeared right after accept");

endmodule

bind lms_load_predictor_score lps_checker u_lps_checker (.*);

FILE: sim/lms_load_predictor_score_tb.sv
// testbench for the lms load predictor score block: self-predicting, randomized, with back-pressure
`timescale 1ns / 100ps

module lms_load_predictor_score_tb;
	import lps_pkg::*;

	localparam int FB         = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 3000;
	localparam int DRAIN      = 600;
	localparam int N_RANDOM   = 780;
	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [LR_W-1:0]    cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic               init_report = 1'b0;
	logic [BW_W-1:0]    bw_sample = '0;
	logic [SAMP_W-1:0]  ram_sample = '0;
	logic [SAMP_W-1:0]  cpu_sample = '0;
	logic               allocated = 1'b0;
	logic [SAMP_W-1:0]  job_size = '0;
	logic [LEN_W-1:0]   job_length = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SCORE_W-1:0] score;

	lms_load_predictor_score DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .init_report(init_report),
		.bw_sample(bw_sample), .ram_sample(ram_sample), .cpu_sample(cpu_sample),
		.allocated(allocated), .job_size(job_size), .job_length(job_length),
		.out_valid(out_valid), .out_stall(out_stall), .score(score)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [LR_W-1:0] step_size;
	sword_t wt_cpu, wt_ram, wt_bw, wt_bias;
	logic [BW_W-1:0]   prev_bw;
	logic [SAMP_W-1:0] prev_ram, prev_cpu;

	logic [SCORE_W-1:0] score_q[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  calm = 0;
	bit  hold_req = 0;
	int  hold_cnt = 0;

	function automatic sword_t add_clip(sword_t a, sword_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic sword_t sub_clip(sword_t a, sword_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic sword_t weight_clip(sword_t v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF)
			return 64'sh0000_7FFF_FFFF_FFFF;
		if (v < -64'sh0000_8000_0000_0000)
			return -64'sh0000_8000_0000_0000;
		return v;
	endfunction

	// exact product, floor shift, clipped to 64 bits
	function automatic sword_t fx_mul(sword_t a, sword_t b);
		logic signed [127:0] wa, wb, p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> FB;
		if (p[127:63] != {65{p[127]}})
			return p[127] ? S64_MIN : S64_MAX;
		return p[63:0];
	endfunction

	task automatic model_reset();
		step_size = 17'd6554;
		wt_cpu = 64'sd65536;
		wt_ram = 64'sd65536;
		wt_bw = 64'sd65536;
		wt_bias = 64'sd65536;
		prev_bw = '0;
		prev_ram = '0;
		prev_cpu = '0;
	endtask

	task automatic predict_transaction(logic c, logic ir, logic [BW_W-1:0] bw,
			logic [SAMP_W-1:0] ram, logic [SAMP_W-1:0] cpu, logic al,
			logic [SAMP_W-1:0] js, logic [LEN_W-1:0] jl);
		sword_t x, y, z, e, g, h_bw, h_ram, h_cpu, q, pred, best;
		logic [LEN_W-1:0] len;
		if (c == CMD_REPORT) begin
			if (!ir) begin
				x = sword_t'(prev_cpu);
				y = sword_t'(prev_ram);
				z = (sword_t'(bw) - sword_t'(prev_bw)) <<< FB;
				e = sword_t'(cpu);
				e = sub_clip(e, fx_mul(wt_cpu, x));
				e = sub_clip(e, fx_mul(wt_ram, y));
				e = sub_clip(e, fx_mul(wt_bw, z));
				e = sub_clip(e, wt_bias);
				g = fx_mul(sword_t'(step_size), e);
				wt_cpu = weight_clip(add_clip(wt_cpu, fx_mul(g, x)));
				wt_ram = weight_clip(add_clip(wt_ram, fx_mul(g, y)));
				wt_bw = weight_clip(add_clip(wt_bw, fx_mul(g, z)));
				wt_bias = weight_clip(add_clip(wt_bias, g));
			end
			prev_bw = bw;
			prev_ram = ram;
			prev_cpu = cpu;
		end else begin
			h_bw = (BW_FULL - sword_t'(prev_bw)) <<< FB;
			h_ram = 64'sd65536 - sword_t'(prev_ram);
			h_cpu = 64'sd65536 - sword_t'(prev_cpu);
			if (al) begin
				len = (jl == 0) ? 16'd1 : jl;
				q = sword_t'(js / len);
				h_bw = sub_clip(h_bw, q);
				h_ram = sub_clip(h_ram, sword_t'(js));
				pred = fx_mul(wt_cpu, sword_t'(prev_cpu));
				pred = add_clip(pred, fx_mul(wt_ram, sword_t'(prev_ram)));
				pred = add_clip(pred, fx_mul(wt_bw, q));
				pred = add_clip(pred, wt_bias);
				h_cpu = sub_clip(h_cpu, pred);
			end
			h_bw = fx_mul(h_bw, h_bw);
			h_ram = fx_mul(h_ram, h_ram);
			h_cpu = fx_mul(h_cpu, h_cpu);
			best = h_bw;
			if (h_ram > best) best = h_ram;
			if (h_cpu > best) best = h_cpu;
			if (best < 0) best = 0;
			score_q.push_back(best[SCORE_W-1:0]);
		end
	endtask

	// called just after a rising edge; returns at the edge that accepts the transaction
	task automatic send_item(logic c, logic ir, logic [BW_W-1:0] bw,
			logic [SAMP_W-1:0] ram, logic [SAMP_W-1:0] cpu, logic al,
			logic [SAMP_W-1:0] js, logic [LEN_W-1:0] jl);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		init_report <= ir;
		bw_sample <= bw;
		ram_sample <= ram;
		cpu_sample <= cpu;
		allocated <= al;
		job_size <= js;
		job_length <= jl;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_transaction(c, ir, bw, ram, cpu, al, js, jl);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (score_q.size() != 0) @(posedge clk);
		// reports leave no result, so give the last one time to finish
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_rate(logic [LR_W-1:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		step_size = v;
	endtask

	function automatic logic [BW_W-1:0] pick_bw();
		case ($urandom_range(3))
			0, 1: return 30'(1000000000 - $urandom_range(0, 50000));
			2: return 30'($urandom);
			default: return 30'($urandom_range(0, 1000000));
		endcase
	endfunction

	function automatic logic [SAMP_W-1:0] pick_frac();
		if ($urandom_range(9) == 0) return 17'($urandom);
		return 17'($urandom_range(0, 65536));
	endfunction

	task automatic send_random();
		logic [LEN_W-1:0] jl;
		jl = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		send_item(1'($urandom), 1'($urandom_range(3) == 0), pick_bw(), pick_frac(),
			pick_frac(), 1'($urandom), pick_frac(), jl);
	endtask

	task automatic test_reset_state();
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b0, '0, 16'd1);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd65536, 16'd0);
	endtask

	task automatic test_field_extremes();
		send_item(CMD_REPORT, 1'b1, 30'd1000000000, 17'd65536, 17'd65536, 1'b1, '1, '1);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b0, '0, 16'd1);
		send_item(CMD_REPORT, 1'b0, 30'd999999000, 17'd0, 17'd0, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b1, '1, '1, '1, 1'b1, 17'd65536, 16'd65535);
		send_item(CMD_REPORT, 1'b0, '1, '1, '1, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, '1, 16'd0);
		send_item(CMD_REPORT, 1'b1, 30'd1000000000, 17'd32768, 17'd16384, 1'b0, '0, '0);
		send_item(CMD_REPORT, 1'b0, 30'd1000000000, 17'd40000, 17'd20000, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd65536, 16'd1);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd3, 16'd2);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b0, '1, 16'd0);
	endtask

	task automatic test_rate_settings();
		write_rate(17'd0);
		send_item(CMD_REPORT, 1'b0, 30'd999990000, 17'd1000, 17'd60000, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd500, 16'd7);
		write_rate(17'd65536);
		send_item(CMD_REPORT, 1'b0, 30'd999999999, 17'd2000, 17'd100, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd9000, 16'd3);
		write_rate(17'd1);
		send_item(CMD_REPORT, 1'b0, 30'd999999000, 17'd65535, 17'd1, 1'b0, '0, '0);
		send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'b1, 17'd1, 16'd1);
		write_rate(17'd6554);
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		repeat (4) send_item(CMD_QUERY, 1'b0, '0, '0, '0, 1'($urandom), pick_frac(),
			16'($urandom));
	endtask

	task automatic test_random();
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 200 && i < 300);
			if (i % 200 == 199)
				write_rate(17'($urandom_range(0, 65536)));
			send_random();
		end
		calm = 0;
	endtask

	// receiver: random stall, a quiet stretch, and one long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt <= HOLD_LEN;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		logic [SCORE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (score_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: score %0d with no transaction pending", $realtime, score);
			end else begin
				want = score_q.pop_front();
				if (score !== want) begin
					errors++;
					if (errors <= 10)
						$display("%0t: score mismatch expected %0d actual %0d",
							$realtime, want, score);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_field_extremes();
		test_rate_settings();
		test_backpressure();
		test_random();
		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: lms_load_predictor_score.f
rtl/lps_pkg.sv
rtl/lps_mulq.sv
rtl/lps_div.sv
rtl/lps_datapath.sv
rtl/lps_ctrl.sv
rtl/lms_load_predictor_score.sv
rtl/lps_checker.sv
sim/lms_load_predictor_score_tb.sv
